FILE: hdl/s2b_pkg.sv
// Shared types, widths and codes for the space-to-batch region descriptor generator.
`default_nettype none

package s2b_pkg;

  // Default limit on descriptors emitted per operation.
  localparam int MAX_REGIONS_DEF = 64;

  // Datapath widths.
  localparam int WORD_W     = 32;
  localparam int NUM_W      = 14;
  localparam int DEN_W      = 7;
  localparam int DIM_W      = 13;
  localparam int BATCH_W    = 9;
  localparam int PAD_W      = 12;
  localparam int OUTER_W    = 21;
  localparam int IN_DATA_W  = 112;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 304;

  // Saturation value of the outer element count.
  localparam logic [OUTER_W-1:0] OUTER_MAX = '1;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC_ISSUE,
    ST_MAC_WAIT,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_EMIT
  } state_t;

  // Multiply-add operations, in issue order. The first group runs once per
  // operation, the second group once per region.
  typedef enum logic [4:0] {
    OP_IHW,
    OP_OHW,
    OP_BT0,
    OP_IBBT0,
    OP_OUTER,
    OP_IWC,
    OP_OWC,
    OP_SROW,
    OP_SCOL,
    OP_HSTART,
    OP_WSTART,
    OP_SOFF_H,
    OP_SOFF_W,
    OP_DOFF_H,
    OP_DOFF_W,
    OP_DOFF_R
  } mac_op_t;

  // Divisions of a region: row start, row end, column start, column end; the row pair only on a new row phase.
  typedef enum logic [1:0] {
    DIV_HS,
    DIV_HE,
    DIV_WS,
    DIV_WE
  } div_op_t;

  // Request to the shared multiply-add unit.
  typedef struct packed {
    logic              en;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic [WORD_W-1:0] c;
  } mac_req_t;

  // Request to the iterative divider.
  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

endpackage

`default_nettype wire

FILE: hdl/space_to_batch_region_descriptors.sv
// Top level of the space-to-batch region descriptor generator.
//
// Usage: one transaction on the in_ channel describes a whole space-to-batch
// or batch-to-space operation. The block answers with min(block_h*block_w,
// MAX_REGIONS) copy descriptors on the out_ channel, one per region, and sets
// out_tlast on the final one. in_tready is high only while the block is idle.
// Sequence: after acceptance, nine multiply-add steps set up the strides. Each
// region then needs two divisions (four on the first region of a row phase)
// on the bit-serial divider, which yields one quotient bit per cycle, plus
// seven multiply-add steps, after which the descriptor is offered.
// A stalled receiver simply holds the descriptor on out_tdata; the block waits
// and resumes when out_tready rises. Reset (rst_n low, synchronous) returns the
// sequencer to idle and drops any operation in progress.
`default_nettype none

module space_to_batch_region_descriptors #(
  parameter int MAX_REGIONS = s2b_pkg::MAX_REGIONS_DEF
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_tvalid,
  output logic                              in_tready,
  // in_height, in_width, in_batch, out_height, out_width, channel,
  // block_h, block_w, pad_top, pad_left
  input  wire  [s2b_pkg::IN_DATA_W-1:0]     in_tdata,
  // nhwc_layout, batch_to_space
  input  wire  [s2b_pkg::IN_USER_W-1:0]     in_tuser,
  output logic                              out_tvalid,
  input  wire                               out_tready,
  // src_offset, src_stride_outer, src_stride_row, src_stride_col,
  // dst_offset, dst_stride_outer, dst_stride_row, dst_stride_col,
  // count_outer, count_rows, count_cols, one zero pad bit
  output logic [s2b_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic                              out_tlast
);

  localparam int W      = s2b_pkg::WORD_W;
  localparam int NW     = s2b_pkg::NUM_W;
  localparam int DW     = s2b_pkg::DEN_W;
  localparam int DIMW   = s2b_pkg::DIM_W;
  localparam int BW     = s2b_pkg::BATCH_W;
  localparam int PW     = s2b_pkg::PAD_W;
  localparam int OW     = s2b_pkg::OUTER_W;
  localparam int PROD_W = 2 * DW;
  localparam int RCNT_W = $clog2(MAX_REGIONS + 1);

  // Sequencer.
  s2b_pkg::state_t  state_r, state_nxt;
  s2b_pkg::mac_op_t op_r, op_nxt;
  s2b_pkg::div_op_t dop_r, dop_nxt;

  // Operation fields held for the whole operation.
  logic [DIMW-1:0]   ih_r, iw_r, oh_r, ow_r, ch_r;
  logic [BW-1:0]     ib_r;
  logic [DW-1:0]     bh_r, bw_r;
  logic [PW-1:0]     pt_r, pl_r;
  logic              nhwc_r, b2s_r;
  logic [RCNT_W-1:0] n_r;

  // Per-operation products.
  logic [W-1:0]  ihw_r, ohw_r, bt0_r, ibbt0_r, iwc_r, owc_r, srow_r, scol_r;
  logic [OW-1:0] outer_r;

  // Per-region state.
  logic [RCNT_W-1:0] r_r;
  logic [DW-1:0]     pw_r, ph_r;
  logic [NW-1:0]     hs_r, ws_r;
  logic [DIMW-1:0]   he_r, we_r;
  logic [W-1:0]      hstart_r, wstart_r, soff_r, doff_r;

  // Unit interfaces.
  s2b_pkg::mac_req_t mac_req;
  s2b_pkg::div_req_t div_req;
  logic [W-1:0]      mac_p;
  logic [NW-1:0]     div_quo;
  logic              div_done;

  // Decoded input fields.
  logic [DW-1:0]     in_bh, in_bw;
  logic [PROD_W-1:0] blk_prod;
  logic              in_accept;

  // Derived values.
  logic [W-1:0]      sp1, sp2, sp3, bt1, bt2, bt3;
  logic [NW-1:0]     row_base, col_base, qm1;
  logic [NW-1:0]     rows_diff, cols_diff;
  logic [DIMW-1:0]   count_rows, count_cols;
  logic [RCNT_W-1:0] r_inc;
  logic [DW-1:0]     pw_inc;
  logic              pw_wrap, last;
  logic [4*W-1:0]    spat_desc, batch_desc;

  s2b_mac u_mac (
    .clk (clk),
    .req (mac_req),
    .p   (mac_p)
  );

  s2b_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .quo   (div_quo),
    .done  (div_done)
  );

  // Input decode; a zero block size counts as one.
  assign in_accept = in_tvalid && in_tready;
  assign in_bh     = (in_tdata[80:74] == '0) ? DW'(1) : in_tdata[80:74];
  assign in_bw     = (in_tdata[87:81] == '0) ? DW'(1) : in_tdata[87:81];
  assign blk_prod  = in_bh * in_bw;

  // Region bookkeeping.
  assign r_inc   = r_r + 1'b1;
  assign last    = (r_inc == n_r);
  assign pw_inc  = pw_r + 1'b1;
  assign pw_wrap = (pw_inc == bw_r);

  // Strides of the spatial and batched tensors for the chosen layout.
  assign sp1 = nhwc_r ? W'(1) : ihw_r;
  assign sp2 = nhwc_r ? iwc_r : W'(iw_r);
  assign sp3 = nhwc_r ? W'(ch_r) : W'(1);
  assign bt1 = nhwc_r ? W'(1) : ohw_r;
  assign bt2 = nhwc_r ? owc_r : W'(ow_r);
  assign bt3 = nhwc_r ? W'(ch_r) : W'(1);

  // Dividends of the ceiling divisions: pad - phase + 2*block - 1.
  assign row_base = NW'(pt_r) + NW'({bh_r, 1'b0}) - NW'(1) - NW'(ph_r);
  assign col_base = NW'(pl_r) + NW'({bw_r, 1'b0}) - NW'(1) - NW'(pw_r);
  assign qm1      = div_quo - NW'(1);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    dop_nxt   = dop_r;
    case (state_r)
      s2b_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = s2b_pkg::ST_MAC_ISSUE;
          op_nxt    = s2b_pkg::OP_IHW;
        end
      end
      s2b_pkg::ST_MAC_ISSUE: begin
        state_nxt = s2b_pkg::ST_MAC_WAIT;
      end
      s2b_pkg::ST_MAC_WAIT: begin
        if (op_r == s2b_pkg::OP_SCOL) begin
          state_nxt = s2b_pkg::ST_DIV_START;
          dop_nxt   = s2b_pkg::DIV_HS;
        end else if (op_r == s2b_pkg::OP_DOFF_R) begin
          state_nxt = s2b_pkg::ST_EMIT;
        end else begin
          state_nxt = s2b_pkg::ST_MAC_ISSUE;
          op_nxt    = s2b_pkg::mac_op_t'(op_r + 5'd1);
        end
      end
      s2b_pkg::ST_DIV_START: begin
        state_nxt = s2b_pkg::ST_DIV_WAIT;
      end
      s2b_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          if (dop_r == s2b_pkg::DIV_WE) begin
            state_nxt = s2b_pkg::ST_MAC_ISSUE;
            op_nxt    = s2b_pkg::OP_HSTART;
          end else begin
            state_nxt = s2b_pkg::ST_DIV_START;
            dop_nxt   = s2b_pkg::div_op_t'(dop_r + 2'd1);
          end
        end
      end
      s2b_pkg::ST_EMIT: begin
        if (out_tready) begin
          if (last) begin
            state_nxt = s2b_pkg::ST_IDLE;
          end else begin
            // Row divisions are redone only when the row phase changes.
            state_nxt = s2b_pkg::ST_DIV_START;
            dop_nxt   = pw_wrap ? s2b_pkg::DIV_HS : s2b_pkg::DIV_WS;
          end
        end
      end
      default: begin
        state_nxt = s2b_pkg::ST_IDLE;
      end
    endcase
  end

  // Handshakes and unit requests.
  always_comb begin
    in_tready     = (state_r == s2b_pkg::ST_IDLE);
    out_tvalid    = (state_r == s2b_pkg::ST_EMIT);
    mac_req.en    = (state_r == s2b_pkg::ST_MAC_ISSUE);
    div_req.start = (state_r == s2b_pkg::ST_DIV_START);
  end

  // Operand selection of the multiply-add unit.
  always_comb begin
    mac_req.a = '0;
    mac_req.b = '0;
    mac_req.c = '0;
    case (op_r)
      s2b_pkg::OP_IHW: begin
        mac_req.a = W'(ih_r);
        mac_req.b = W'(iw_r);
      end
      s2b_pkg::OP_OHW: begin
        mac_req.a = W'(oh_r);
        mac_req.b = W'(ow_r);
      end
      s2b_pkg::OP_BT0: begin
        mac_req.a = ohw_r;
        mac_req.b = W'(ch_r);
      end
      s2b_pkg::OP_IBBT0: begin
        mac_req.a = W'(ib_r);
        mac_req.b = bt0_r;
      end
      s2b_pkg::OP_OUTER: begin
        mac_req.a = W'(ib_r);
        mac_req.b = W'(ch_r);
      end
      s2b_pkg::OP_IWC: begin
        mac_req.a = W'(iw_r);
        mac_req.b = W'(ch_r);
      end
      s2b_pkg::OP_OWC: begin
        mac_req.a = W'(ow_r);
        mac_req.b = W'(ch_r);
      end
      s2b_pkg::OP_SROW: begin
        mac_req.a = W'(bh_r);
        mac_req.b = sp2;
      end
      s2b_pkg::OP_SCOL: begin
        mac_req.a = W'(bw_r);
        mac_req.b = sp3;
      end
      s2b_pkg::OP_HSTART: begin
        mac_req.a = W'(hs_r);
        mac_req.b = W'(bh_r);
        mac_req.c = W'(ph_r) - W'(pt_r);
      end
      s2b_pkg::OP_WSTART: begin
        mac_req.a = W'(ws_r);
        mac_req.b = W'(bw_r);
        mac_req.c = W'(pw_r) - W'(pl_r);
      end
      s2b_pkg::OP_SOFF_H: begin
        mac_req.a = hstart_r;
        mac_req.b = sp2;
      end
      s2b_pkg::OP_SOFF_W: begin
        mac_req.a = wstart_r;
        mac_req.b = sp3;
        mac_req.c = soff_r;
      end
      s2b_pkg::OP_DOFF_H: begin
        mac_req.a = W'(hs_r);
        mac_req.b = bt2;
      end
      s2b_pkg::OP_DOFF_W: begin
        mac_req.a = W'(ws_r);
        mac_req.b = bt3;
        mac_req.c = doff_r;
      end
      s2b_pkg::OP_DOFF_R: begin
        mac_req.a = W'(r_r);
        mac_req.b = ibbt0_r;
        mac_req.c = doff_r;
      end
      default: begin
        mac_req.a = '0;
      end
    endcase
  end

  // Operand selection of the divider.
  always_comb begin
    div_req.num = row_base;
    div_req.den = bh_r;
    case (dop_r)
      s2b_pkg::DIV_HS: begin
        div_req.num = row_base;
        div_req.den = bh_r;
      end
      s2b_pkg::DIV_HE: begin
        div_req.num = row_base + NW'(ih_r);
        div_req.den = bh_r;
      end
      s2b_pkg::DIV_WS: begin
        div_req.num = col_base;
        div_req.den = bw_r;
      end
      s2b_pkg::DIV_WE: begin
        div_req.num = col_base + NW'(iw_r);
        div_req.den = bw_r;
      end
      default: begin
        div_req.num = row_base;
      end
    endcase
  end

  // Sequencer registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= s2b_pkg::ST_IDLE;
      op_r    <= s2b_pkg::OP_IHW;
      dop_r   <= s2b_pkg::DIV_HS;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      dop_r   <= dop_nxt;
    end
  end

  // Operation fields are captured with the input transaction.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      ih_r   <= in_tdata[12:0];
      iw_r   <= in_tdata[25:13];
      ib_r   <= in_tdata[34:26];
      oh_r   <= in_tdata[47:35];
      ow_r   <= in_tdata[60:48];
      ch_r   <= in_tdata[73:61];
      bh_r   <= in_bh;
      bw_r   <= in_bw;
      pt_r   <= in_tdata[99:88];
      pl_r   <= in_tdata[111:100];
      nhwc_r <= in_tuser[0];
      b2s_r  <= in_tuser[1];
      if (blk_prod > PROD_W'(MAX_REGIONS)) begin
        n_r <= RCNT_W'(MAX_REGIONS);
      end else begin
        n_r <= RCNT_W'(blk_prod);
      end
    end
  end

  // Region counter and phase counters.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      r_r  <= '0;
      pw_r <= '0;
      ph_r <= '0;
    end else if (out_tvalid && out_tready && !last) begin
      r_r <= r_inc;
      if (pw_wrap) begin
        pw_r <= '0;
        ph_r <= ph_r + 1'b1;
      end else begin
        pw_r <= pw_inc;
      end
    end
  end

  // Multiply-add results go to the register named by the operation.
  always_ff @(posedge clk) begin
    if (state_r == s2b_pkg::ST_MAC_WAIT) begin
      case (op_r)
        s2b_pkg::OP_IHW:    ihw_r    <= mac_p;
        s2b_pkg::OP_OHW:    ohw_r    <= mac_p;
        s2b_pkg::OP_BT0:    bt0_r    <= mac_p;
        s2b_pkg::OP_IBBT0:  ibbt0_r  <= mac_p;
        s2b_pkg::OP_OUTER: begin
          outer_r <= (mac_p > W'(s2b_pkg::OUTER_MAX)) ? s2b_pkg::OUTER_MAX : mac_p[OW-1:0];
        end
        s2b_pkg::OP_IWC:    iwc_r    <= mac_p;
        s2b_pkg::OP_OWC:    owc_r    <= mac_p;
        s2b_pkg::OP_SROW:   srow_r   <= mac_p;
        s2b_pkg::OP_SCOL:   scol_r   <= mac_p;
        s2b_pkg::OP_HSTART: hstart_r <= mac_p;
        s2b_pkg::OP_WSTART: wstart_r <= mac_p;
        s2b_pkg::OP_SOFF_H: soff_r   <= mac_p;
        s2b_pkg::OP_SOFF_W: soff_r   <= mac_p;
        s2b_pkg::OP_DOFF_H: doff_r   <= mac_p;
        s2b_pkg::OP_DOFF_W: doff_r   <= mac_p;
        s2b_pkg::OP_DOFF_R: doff_r   <= mac_p;
        default: begin
          ihw_r <= ihw_r;
        end
      endcase
    end
  end

  // Range bounds from the divider; the quotient is one above the ceiling.
  always_ff @(posedge clk) begin
    if (state_r == s2b_pkg::ST_DIV_WAIT && div_done) begin
      case (dop_r)
        s2b_pkg::DIV_HS: hs_r <= qm1;
        s2b_pkg::DIV_HE: he_r <= (qm1 > NW'(oh_r)) ? oh_r : qm1[DIMW-1:0];
        s2b_pkg::DIV_WS: ws_r <= qm1;
        s2b_pkg::DIV_WE: we_r <= (qm1 > NW'(ow_r)) ? ow_r : qm1[DIMW-1:0];
        default: begin
          hs_r <= hs_r;
        end
      endcase
    end
  end

  // Valid counts; an empty range gives zero.
  assign rows_diff  = NW'(he_r) - hs_r;
  assign cols_diff  = NW'(we_r) - ws_r;
  assign count_rows = (NW'(he_r) > hs_r) ? rows_diff[DIMW-1:0] : '0;
  assign count_cols = (NW'(we_r) > ws_r) ? cols_diff[DIMW-1:0] : '0;

  // Descriptor packing; batch-to-space exchanges source and destination.
  assign spat_desc  = {scol_r, srow_r, sp1, soff_r};
  assign batch_desc = {bt3, bt2, bt1, doff_r};
  assign out_tdata  = b2s_r ?
      {1'b0, count_cols, count_rows, outer_r, spat_desc, batch_desc} :
      {1'b0, count_cols, count_rows, outer_r, batch_desc, spat_desc};
  assign out_tlast  = last;

`ifndef SYNTHESIS
  // The region index stays below the region count while busy.
  a_region_bound: assert property (@(posedge clk) disable iff (!rst_n)
      (state_r != s2b_pkg::ST_IDLE) |-> (r_r < n_r))
    else $error("region index reached region count");

  // Phase counters stay inside the block shape.
  a_phase_bound: assert property (@(posedge clk) disable iff (!rst_n)
      (state_r != s2b_pkg::ST_IDLE) |-> ((pw_r < bw_r) && (ph_r < bh_r)))
    else $error("region phase outside block shape");

  // The final descriptor of an operation returns the block to idle.
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
      (out_tvalid && out_tready && out_tlast) |=> in_tready)
    else $error("block not idle after final descriptor");

  // The clamped row and column ends never exceed the batched height and width.
  a_row_clamp: assert property (@(posedge clk) disable iff (!rst_n)
      out_tvalid |-> (he_r <= oh_r) && (we_r <= ow_r))
    else $error("valid range end above output size");

  // A fresh division never reports done in the cycle after its start.
  a_div_fresh: assert property (@(posedge clk) disable iff (!rst_n)
      (state_r == s2b_pkg::ST_DIV_START) |=> !div_done)
    else $error("divider done flag not cleared by start");
`endif

endmodule

`default_nettype wire

FILE: hdl/s2b_div.sv
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none

module s2b_div (
  input  wire                         clk,
  input  wire                         rst_n,
  input  s2b_pkg::div_req_t           req,
  output logic [s2b_pkg::NUM_W-1:0]   quo,
  output logic                        done
);

  localparam int NW    = s2b_pkg::NUM_W;
  localparam int DW    = s2b_pkg::DEN_W;
  localparam int CNT_W = $clog2(NW + 1);

  logic [CNT_W-1:0] cnt_r;
  logic [DW-1:0]    rem_r;
  logic [DW-1:0]    den_r;
  logic [NW-1:0]    quo_r;
  logic             done_r;
  logic [DW:0]      trial;
  logic [DW:0]      diff;
  logic             fits;

  // One trial subtraction of the shifted remainder.
  assign trial = {rem_r, quo_r[NW-1]};
  assign diff  = trial - {1'b0, den_r};
  assign fits  = trial >= {1'b0, den_r};

  // Control: bit counter and completion flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (req.start) begin
      cnt_r  <= CNT_W'(NW);
      done_r <= 1'b0;
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        done_r <= 1'b1;
      end
    end
  end

  // Data: the dividend shifts out while quotient bits shift in.
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.num;
      rem_r <= '0;
      den_r <= req.den;
    end else if (cnt_r != '0) begin
      quo_r <= {quo_r[NW-2:0], fits};
      rem_r <= fits ? diff[DW-1:0] : trial[DW-1:0];
    end
  end

  assign quo  = quo_r;
  assign done = done_r;

endmodule

`default_nettype wire

FILE: hdl/s2b_mac.sv
// Shared multiply-add unit with a registered 32-bit result.
`default_nettype none

module s2b_mac (
  input  wire                          clk,
  input  s2b_pkg::mac_req_t            req,
  output logic [s2b_pkg::WORD_W-1:0]   p
);

  logic [s2b_pkg::WORD_W-1:0] p_r;

  // Product and sum wrap modulo 2^32.
  always_ff @(posedge clk) begin
    if (req.en) begin
      p_r <= req.a * req.b + req.c;
    end
  end

  assign p = p_r;

endmodule

`default_nettype wire
